[src/rde_pkg.sv]
// Shared types and constants of the signed radix digit emitter.
`timescale 1ns / 1ps

package rde_pkg;

  localparam int VALUE_W = 32;
  localparam int CFG_W   = 64;
  localparam int DC_W    = 5;
  localparam int DIGIT_W = 4;
  localparam int ALPHA_N = 16;
  localparam int CHAR_W  = 8;

  typedef logic [CHAR_W-1:0]              char_t;
  typedef logic [DIGIT_W-1:0]             digit_t;
  typedef logic [DC_W-1:0]                dcount_t;
  typedef logic [ALPHA_N-1:0][CHAR_W-1:0] alpha_t;
  typedef logic [1:0]                     reg_idx_t;

  localparam reg_idx_t REG_DIGIT_COUNT  = 2'd0;
  localparam reg_idx_t REG_ALPHABET_LOW = 2'd1;
  localparam reg_idx_t REG_ALPHABET_HI  = 2'd2;

  localparam char_t CHAR_PLUS  = 8'h2B;
  localparam char_t CHAR_MINUS = 8'h2D;

  localparam dcount_t     RST_DIGIT_COUNT  = 5'd10;
  localparam logic [63:0] RST_ALPHABET_LOW = 64'h3736_3534_3332_3130;
  localparam logic [63:0] RST_ALPHABET_HI  = 64'h0000_0000_0000_3938;

  typedef struct packed {
    logic done;
    logic ok;
  } chk_status_t;

endpackage

[src/signed_radix_digit_emitter.sv]
// Top level: writes a signed integer as text in a configured radix and alphabet.
`timescale 1ns / 1ps
//
// Usage:
//   Raise start with in_value while busy is low; the item is taken at that edge.
//   The block then emits one character per out_valid strobe, most significant
//   digit first, a leading '-' for a negative value, out_last on the final one.
//   An invalid radix or alphabet yields no characters at all.
//   Configuration: cfg_we with cfg_index 0 (digit count), 1 (characters 0..7),
//   2 (characters 8..15), data on cfg_data; write only while busy is low and
//   the previous item's characters are out.
// Operation:
//   Digits come from a bit-serial divider, one quotient bit per cycle. The
//   busy flag drops before an item's last character is out. The alphabet
//   check runs alongside the first division.
//   The '-' appears once division and the alphabet check are both done;
//   digits then stream one per cycle.
// Reset: synchronous; clears control state and restores radix 10 with "0".."9".
// The receiver cannot stall: each character is valid for exactly one cycle.
//
module signed_radix_digit_emitter #(
  parameter int MAX_DIGITS = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [rde_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  output rde_pkg::char_t                      out_character,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  rde_pkg::reg_idx_t                   cfg_index,
  input  logic [rde_pkg::CFG_W-1:0]           cfg_data
);
  import rde_pkg::*;

  localparam int AW = $clog2(VALUE_BITS);
  localparam int DW = $clog2(VALUE_BITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  dcount_t     digit_count_r;
  logic [63:0] alpha_low_r;
  logic [63:0] alpha_high_r;
  alpha_t      alphabet;

  logic [1:0]    state_r, state_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [DW-1:0] depth_m1;
  logic          neg_r, neg_nxt;

  logic [VALUE_BITS-1:0] v_in;
  logic [VALUE_BITS-1:0] mag_in;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [VALUE_BITS-1:0] div_q;
  digit_t                div_rem;
  logic                  div_start;
  logic                  div_done;

  chk_status_t chk;
  logic        chk_start;

  logic   push;
  logic   rd_en;
  digit_t rd_data;
  logic   enter_emit;

  logic  rd_v_r, rd_last_r;
  logic  out_valid_r, out_valid_nxt;
  char_t out_char_r, out_char_nxt;
  logic  out_last_r, out_last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r <= RST_DIGIT_COUNT;
      alpha_low_r   <= RST_ALPHABET_LOW;
      alpha_high_r  <= RST_ALPHABET_HI;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIGIT_COUNT:  digit_count_r <= cfg_data[DC_W-1:0];
        REG_ALPHABET_LOW: alpha_low_r   <= cfg_data[63:0];
        REG_ALPHABET_HI:  alpha_high_r  <= cfg_data[63:0];
        default: ;
      endcase
    end
  end

  assign alphabet = {alpha_high_r, alpha_low_r};

  assign v_in     = in_value[VALUE_BITS-1:0];
  assign mag_in   = v_in[VALUE_BITS-1] ? (~v_in + VALUE_BITS'(1)) : v_in;
  assign depth_m1 = depth_r - DW'(1);

  always_comb begin
    state_nxt    = state_r;
    depth_nxt    = depth_r;
    neg_nxt      = neg_r;
    div_start    = 1'b0;
    div_dividend = div_q;
    chk_start    = 1'b0;
    push         = 1'b0;
    rd_en        = 1'b0;
    enter_emit   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          chk_start    = 1'b1;
          div_start    = 1'b1;
          div_dividend = mag_in;
          neg_nxt      = v_in[VALUE_BITS-1];
          depth_nxt    = '0;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (chk.done && !chk.ok) begin
          state_nxt = ST_IDLE;
        end else if (div_done) begin
          push      = 1'b1;
          depth_nxt = depth_r + DW'(1);
          if (div_q != '0) begin
            div_start = 1'b1;
          end else if (chk.done) begin
            enter_emit = 1'b1;
            state_nxt  = ST_EMIT;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (chk.done) begin
          if (chk.ok) begin
            enter_emit = 1'b1;
            state_nxt  = ST_EMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        rd_en     = 1'b1;
        depth_nxt = depth_m1;
        if (depth_r == DW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    if (enter_emit && neg_r) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = CHAR_MINUS;
      out_last_nxt  = 1'b0;
    end else begin
      out_valid_nxt = rd_v_r;
      out_char_nxt  = alphabet[rd_data];
      out_last_nxt  = rd_v_r && rd_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      depth_r     <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      rd_v_r      <= rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    rd_last_r  <= (depth_r == DW'(1));
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  rde_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .radix    (digit_count_r),
    .done     (div_done),
    .quotient (div_q),
    .remainder(div_rem)
  );

  rde_base_check #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (chk_start),
    .digit_count(digit_count_r),
    .alphabet   (alphabet),
    .status     (chk)
  );

  rde_stack #(
    .DEPTH(VALUE_BITS)
  ) u_stack (
    .clk    (clk),
    .wr_en  (push),
    .wr_addr(depth_r[AW-1:0]),
    .wr_data(div_rem),
    .rd_en  (rd_en),
    .rd_addr(depth_m1[AW-1:0]),
    .rd_data(rd_data)
  );

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

[src/rde_divider.sv]
// Bit-serial restoring divider by the radix, one quotient bit per cycle.
`timescale 1ns / 1ps

module rde_divider #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  rde_pkg::dcount_t      radix,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output rde_pkg::digit_t       remainder
);
  import rde_pkg::*;

  localparam int CW = $clog2(VALUE_BITS + 1);

  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic [VALUE_BITS-1:0] q_r, q_nxt;
  digit_t                rem_r, rem_nxt;
  logic [DC_W-1:0]       trial;
  logic                  qbit;

  always_comb begin
    trial    = {rem_r, q_r[VALUE_BITS-1]};
    qbit     = (trial >= radix);
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (start) begin
      cnt_nxt = CW'(VALUE_BITS);
      q_nxt   = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
      q_nxt    = {q_r[VALUE_BITS-2:0], qbit};
      rem_nxt  = qbit ? DIGIT_W'(trial - radix) : DIGIT_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

[src/rde_base_check.sv]
// Serial sweep over the alphabet that flags a bad radix or a bad digit set.
`timescale 1ns / 1ps

module rde_base_check #(
  parameter int MAX_DIGITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  rde_pkg::dcount_t     digit_count,
  input  rde_pkg::alpha_t      alphabet,
  output rde_pkg::chk_status_t status
);
  import rde_pkg::*;

  localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [IW-1:0] IDX_LAST = IW'(MAX_DIGITS - 1);
  localparam dcount_t       MAXD     = DC_W'(MAX_DIGITS);

  logic [IW-1:0] idx_r, idx_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic          ok_r, ok_nxt;
  char_t         cur;
  logic          dup;
  logic          bad;

  always_comb begin
    cur = alphabet[$clog2(ALPHA_N)'(idx_r)];
    dup = 1'b0;
    for (int j = 0; j < MAX_DIGITS; j++) begin
      if ((DC_W'(j) > DC_W'(idx_r)) && (DC_W'(j) < digit_count) && (alphabet[j] == cur)) begin
        dup = 1'b1;
      end
    end
    bad = (DC_W'(idx_r) < digit_count) &&
          ((cur == CHAR_PLUS) || (cur == CHAR_MINUS) || dup);
  end

  always_comb begin
    idx_nxt  = idx_r;
    run_nxt  = run_r;
    done_nxt = done_r;
    ok_nxt   = ok_r;
    if (start) begin
      idx_nxt = '0;
      ok_nxt  = 1'b0;
      if ((digit_count < DC_W'(2)) || (digit_count > MAXD)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        run_nxt  = 1'b1;
        done_nxt = 1'b0;
      end
    end else if (run_r) begin
      if (bad) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else if (idx_r == IDX_LAST) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
        ok_nxt   = 1'b1;
      end else begin
        idx_nxt = idx_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
      ok_r   <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
      ok_r   <= ok_nxt;
    end
  end

  assign status.done = done_r;
  assign status.ok   = ok_r;

endmodule

[src/rde_stack.sv]
// Digit stack memory with one write port and a registered read port.
`timescale 1ns / 1ps

module rde_stack #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  rde_pkg::digit_t          wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output rde_pkg::digit_t          rd_data
);
  import rde_pkg::*;

  digit_t mem [DEPTH];
  digit_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/rde_checker.sv]
// Port-level checks on the digit emitter, bound to the top level.
`timescale 1ns / 1ps

module rde_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input rde_pkg::char_t out_character,
  input logic           out_last
);
  import rde_pkg::*;

  a_last_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid)
    else $error("out_last without out_valid");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && start && !busy) |=> busy)
    else $error("busy not raised after an item was taken");

  a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("character strobed right after the final one");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_character == CHAR_MINUS)) |-> !out_last)
    else $error("sign character marked as final");

endmodule

bind signed_radix_digit_emitter rde_checker u_rde_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_character(out_character),
  .out_last     (out_last)
);

[tb/tb_signed_radix_digit_emitter.sv]
// Self-checking testbench for the signed radix digit emitter.
`timescale 1ns / 1ps

module tb_signed_radix_digit_emitter;
  import rde_pkg::*;

  localparam reg_idx_t REG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 1200;

  class radix_text_board;
    dcount_t     radix_cfg;
    logic [63:0] low_cfg;
    logic [63:0] high_cfg;
    char_t       want_char[$];
    logic        want_last[$];
    int          errors;

    function new();
      radix_cfg = RST_DIGIT_COUNT;
      low_cfg   = RST_ALPHABET_LOW;
      high_cfg  = RST_ALPHABET_HI;
      errors    = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_DIGIT_COUNT:  radix_cfg = data[DC_W-1:0];
        REG_ALPHABET_LOW: low_cfg = data;
        REG_ALPHABET_HI:  high_cfg = data;
        default: ;
      endcase
    endfunction

    function char_t glyph(digit_t d);
      logic [63:0] word;
      word = d[3] ? high_cfg : low_cfg;
      return word[d[2:0]*8 +: 8];
    endfunction

    function bit base_ok();
      int n;
      char_t c;
      n = radix_cfg;
      if (n < 2 || n > ALPHA_N) return 0;
      for (int i = 0; i < n; i++) begin
        c = glyph(digit_t'(i));
        if (c == CHAR_PLUS || c == CHAR_MINUS) return 0;
        for (int j = i + 1; j < n; j++)
          if (glyph(digit_t'(j)) == c) return 0;
      end
      return 1;
    endfunction

    // Spell one accepted item into the expected character queue.
    function void spell_value(logic [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] mag;
      logic [VALUE_W-1:0] radix;
      digit_t             digits[32];
      int                 depth;
      depth = 0;
      if (!base_ok()) return;
      radix = VALUE_W'(radix_cfg);
      mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
      if (mag == 0) begin
        digits[0] = '0;
        depth = 1;
      end else begin
        while (mag != 0 && depth < 32) begin
          digits[depth] = digit_t'(mag % radix);
          mag = mag / radix;
          depth++;
        end
      end
      if (v[VALUE_W-1]) begin
        want_char.push_back(CHAR_MINUS);
        want_last.push_back(1'b0);
      end
      while (depth > 0) begin
        depth--;
        want_char.push_back(glyph(digits[depth]));
        want_last.push_back(depth == 0);
      end
    endfunction

    function void check(char_t c, logic l);
      char_t e_c;
      logic  e_l;
      if (want_char.size() == 0) begin
        $error("character: expected none, got %h", c);
        errors++;
        return;
      end
      e_c = want_char.pop_front();
      e_l = want_last.pop_front();
      if (c !== e_c) begin
        $error("character: expected %h, got %h", e_c, c);
        errors++;
      end
      if (l !== e_l) begin
        $error("last: expected %b, got %b", e_l, l);
        errors++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic signed [VALUE_W-1:0]  in_value;
  logic                       out_valid;
  char_t                      out_character;
  logic                       out_last;
  logic                       cfg_we;
  reg_idx_t                   cfg_index;
  logic [CFG_W-1:0]           cfg_data;

  radix_text_board board = new();
  int gap_pct;

  signed_radix_digit_emitter u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_character(out_character),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_signed_radix_digit_emitter: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) board.check(out_character, out_last);
  end

  function automatic alpha_t pack_text(string s);
    alpha_t a;
    a = '0;
    for (int i = 0; i < s.len(); i++) a[i] = s[i];
    return a;
  endfunction

  task automatic send_value(logic [VALUE_W-1:0] v);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    start    <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy);
    board.spell_value(v);
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (board.want_char.size() != 0) @(posedge clk);
  endtask

  task automatic drain();
    hold_until_drained();
    while (busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(dcount_t n, alpha_t a);
    logic [CFG_W-1:0] data;
    data = {$urandom, $urandom};
    data[DC_W-1:0] = n;
    cfg_we    <= 1'b1;
    cfg_index <= REG_DIGIT_COUNT;
    cfg_data  <= data;
    @(posedge clk);
    board.set_reg(REG_DIGIT_COUNT, data);
    cfg_index <= REG_ALPHABET_LOW;
    cfg_data  <= a[7:0];
    @(posedge clk);
    board.set_reg(REG_ALPHABET_LOW, a[7:0]);
    cfg_index <= REG_ALPHABET_HI;
    cfg_data  <= a[15:8];
    @(posedge clk);
    board.set_reg(REG_ALPHABET_HI, a[15:8]);
    data = {$urandom, $urandom};
    cfg_index <= REG_SPARE;
    cfg_data  <= data;
    @(posedge clk);
    board.set_reg(REG_SPARE, data);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int kind;
    kind = $urandom_range(9);
    case (kind)
      0, 1, 2, 3: return $urandom;
      4, 5:       return VALUE_W'($signed($urandom_range(600)) - 300);
      6: begin
        case ($urandom_range(4))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      default: begin
        if ($urandom_range(1)) return $urandom >> $urandom_range(31);
        return ~($urandom >> $urandom_range(31)) + 1'b1;
      end
    endcase
  endfunction

  // Build a random alphabet; mostly valid, sometimes broken in one way.
  task automatic random_setup();
    alpha_t  a;
    dcount_t n;
    int      kind;
    int      i;
    int      j;
    bit      clash;
    for (int k = 0; k < ALPHA_N; k++) a[k] = char_t'($urandom);
    n = dcount_t'($urandom_range(2, ALPHA_N));
    for (int k = 0; k < n; k++) begin
      do begin
        a[k] = char_t'($urandom);
        clash = (a[k] == CHAR_PLUS) || (a[k] == CHAR_MINUS);
        for (int m = 0; m < k; m++) if (a[m] == a[k]) clash = 1;
      end while (clash);
    end
    kind = $urandom_range(9);
    if (kind == 0) begin
      do n = dcount_t'($urandom); while (n >= 2 && n <= ALPHA_N);
    end else if (kind == 1) begin
      i = $urandom_range(n - 2);
      j = $urandom_range(i + 1, n - 1);
      a[j] = a[i];
    end else if (kind == 2) begin
      a[$urandom_range(n - 1)] = $urandom_range(1) ? CHAR_PLUS : CHAR_MINUS;
    end
    write_config(n, a);
  endtask

  initial begin
    alpha_t a;
    int     pct_list[3];
    rst_n     = 1'b0;
    start     = 1'b0;
    in_value  = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_DIGIT_COUNT;
    cfg_data  = '0;
    gap_pct   = 15;
    pct_list  = '{15, 71, 0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // decimal from reset
    send_value(32'd0);
    send_value(32'd7);
    send_value(-32'sd7);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'd1_000_000_000);
    send_value(32'hFFFF_FFFF);
    drain();

    write_config(5'd2, pack_text("01"));
    send_value(32'd0);
    send_value(32'd5);
    send_value(32'h8000_0000);
    send_value(32'hFFFF_FFFF);
    drain();

    write_config(5'd16, pack_text("0123456789abcdef"));
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'hDEAD_BEEF);
    drain();

    // zero byte as an ordinary digit
    a = '0;
    a[1] = "x";
    a[2] = "y";
    write_config(5'd3, a);
    send_value(32'd0);
    send_value(-32'sd5);
    drain();

    // plus sign outside the digits in use
    write_config(5'd4, pack_text("wxyz+"));
    send_value(-32'sd100);
    drain();

    write_config(5'd0, pack_text("0123456789"));
    send_value(32'd42);
    drain();
    write_config(5'd1, pack_text("0123456789"));
    send_value(32'd42);
    drain();
    write_config(5'd17, pack_text("0123456789abcdef"));
    send_value(32'd42);
    drain();
    write_config(5'd8, pack_text("01234516"));
    send_value(32'd42);
    drain();
    write_config(5'd6, pack_text("012+45"));
    send_value(32'd42);
    drain();
    write_config(5'd12, pack_text("0123456789a-"));
    send_value(32'd42);
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      gap_pct = pct_list[mode];
      for (int ph = 0; ph < 4; ph++) begin
        random_setup();
        for (int k = 0; k < 17; k++) begin
          if (mode == 0 && ph == 1 && k == 8) hold_until_drained();
          send_value(pick_value());
        end
        drain();
      end
    end

    if (board.errors == 0) begin
      $display("tb_signed_radix_digit_emitter: done, clean");
    end else begin
      $display("tb_signed_radix_digit_emitter: done, errors");
    end
    $finish;
  end

endmodule

[signed_radix_digit_emitter.f]
src/rde_pkg.sv
src/rde_divider.sv
src/rde_base_check.sv
src/rde_stack.sv
src/signed_radix_digit_emitter.sv
src/rde_checker.sv
tb/tb_signed_radix_digit_emitter.sv
